FILE: hdl/odo_pkg.sv
// Shared types, constants and arithmetic helpers for the planar odometry integrator.
// No dependencies; every other file but odo_mul refers to it by scoped names.
package odo_pkg;

  localparam logic [1:0] ACT_UPDATE   = 2'd0;
  localparam logic [1:0] ACT_SET_POSE = 2'd1;
  localparam logic [1:0] ACT_START    = 2'd2;

  localparam logic [2:0] MUL_RATE_DT  = 3'd0;
  localparam logic [2:0] MUL_TURN     = 3'd1;
  localparam logic [2:0] MUL_SPEED_DT = 3'd2;
  localparam logic [2:0] MUL_DIST_COS = 3'd3;
  localparam logic [2:0] MUL_DIST_SIN = 3'd4;

  localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032875;

  typedef struct packed {
    logic       load_dt;
    logic       mul_start;
    logic [2:0] mul_sel;
    logic       store_p;
    logic       store_q;
    logic       store_dist;
    logic       cor_start;
    logic       cor_sel;
    logic       store_trig;
    logic       upd_x;
    logic       upd_y;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic cor_done;
    logic out_busy;
  } status_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // arithmetic shift of a 128-bit product, saturated to 64 bits
  function automatic logic [63:0] shift_sat(input logic [127:0] v, input logic [5:0] s);
    logic [127:0] sh;
    sh = $signed(v) >>> s;
    if ((&sh[127:63]) || !(|sh[127:63])) return sh[63:0];
    return v[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  // clamp displacement to +-2^33, add, saturate to 32 bits
  function automatic logic [31:0] move_axis(input logic [31:0] pos, input logic [63:0] d);
    logic signed [63:0] dc;
    logic signed [35:0] r;
    dc = $signed(d);
    if (dc > 64'sh2_0000_0000) dc = 64'sh2_0000_0000;
    if (dc < -64'sh2_0000_0000) dc = -64'sh2_0000_0000;
    r = $signed({{4{pos[31]}}, pos}) + $signed(dc[35:0]);
    if (r > 36'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (r < -36'sh0_8000_0000) return 32'h8000_0000;
    return r[31:0];
  endfunction

  function automatic logic [17:0] quat_q16(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic signed [CW:0] r;
    t = $signed({v[CW-1], v}) + (CW+1)'(8192);
    r = t >>> 14;
    if (r > (CW+1)'(65536)) r = (CW+1)'(65536);
    if (r < -(CW+1)'(65536)) r = -(CW+1)'(65536);
    return r[17:0];
  endfunction

endpackage

FILE: hdl/odo_mul.sv
// Sequential 128x64 multiplier: one 32x32 partial product per cycle, accumulated mod 2^128.
// Depends on nothing beyond plain logic; result negated on request.
module odo_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] a_i,
  input  logic [63:0]  b_i,
  input  logic         neg_i,
  output logic [127:0] prod_o,
  output logic         done_o
);

  logic [127:0] a_q;
  logic [63:0]  b_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic [63:0]  pp_q;
  logic [2:0]   off_q;
  logic [3:0]   cnt_q;
  logic         busy_q, done_q;
  logic [31:0]  aw, bw;

  always_comb begin
    aw = a_q[{cnt_q[1:0], 5'd0} +: 32];
    bw = b_q[{cnt_q[2], 5'd0} +: 32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd9) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      neg_q <= neg_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < 4'd8) begin
        pp_q  <= aw * bw;
        off_q <= {1'b0, cnt_q[1:0]} + {2'b0, cnt_q[2]};
      end
      if (cnt_q != 4'd0 && cnt_q < 4'd9) begin
        acc_q <= acc_q + ({64'd0, pp_q} << {off_q, 5'd0});
      end
      if (cnt_q == 4'd9 && neg_q) begin
        acc_q <= 128'd0 - acc_q;
      end
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

FILE: hdl/odo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, binary-angle input.
// Depends on odo_pkg for the arctangent table and gain constant.
module odo_cordic #(
  parameter int ITER = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [31:0]                  ang_i,
  output logic signed [odo_pkg::CW-1:0] sin_o,
  output logic signed [odo_pkg::CW-1:0] cos_o,
  output logic                         done_o
);

  localparam int IW = (ITER > 1) ? $clog2(ITER) : 1;

  logic signed [odo_pkg::CW-1:0] x_q, y_q, z_q, dx, dy, at;
  logic [IW-1:0] i_q;
  logic          busy_q, done_q, flip_q;
  logic [31:0]   ang_p, ang_r;

  always_comb begin
    ang_p = ang_i + 32'h4000_0000;
    ang_r = ang_p[31] ? (ang_i - 32'h8000_0000) : ang_i;
    dx    = y_q >>> i_q;
    dy    = x_q >>> i_q;
    at    = $signed({2'b00, odo_pkg::atan_bam(5'(i_q))});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == IW'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flip_q <= ang_p[31];
      x_q    <= odo_pkg::CORDIC_GAIN_Q30;
      y_q    <= '0;
      z_q    <= $signed({{2{ang_r[31]}}, ang_r});
    end else if (busy_q) begin
      if (!z_q[odo_pkg::CW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign sin_o  = flip_q ? -y_q : y_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign done_o = done_q;

endmodule

FILE: hdl/odo_dpath.sv
// Datapath: pose state, operand muxes, shared multiplier and CORDIC, output register.
// Depends on odo_pkg, odo_mul and odo_cordic.
module odo_dpath #(
  parameter int SINCOS_ITERATIONS = 16,
  parameter int POS_FRAC_BITS     = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  odo_pkg::cmd_t    cmd_i,
  output odo_pkg::status_t sts_o,
  input  logic             in_fire_i,
  input  logic [1:0]       action_i,
  input  logic [31:0]      linear_velocity_i,
  input  logic [31:0]      angular_velocity_i,
  input  logic [63:0]      timestamp_i,
  input  logic [31:0]      new_x_i,
  input  logic [31:0]      new_y_i,
  input  logic [31:0]      new_heading_i,
  input  logic             cfg_wr_en_i,
  input  logic             cfg_wr_data_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [31:0]      pose_x_o,
  output logic [31:0]      pose_y_o,
  output logic [31:0]      pose_heading_o,
  output logic [17:0]      orient_z_o,
  output logic [17:0]      orient_w_o,
  output logic             method_used_o
);

  logic         method_q, meth_q, out_valid_q;
  logic [31:0]  pos_x_q, pos_y_q, head_q, speed_q, rate_q, dh_q, half_q;
  logic [63:0]  ref_q, ts_q, dt_q, dist_q;
  logic [127:0] p_q, prod;
  logic signed [odo_pkg::CW-1:0] sn_q, cs_q, sn, cs;
  logic [127:0] mul_a;
  logic [63:0]  mul_b, trig;
  logic         mul_neg, mul_done, cor_done;
  logic [31:0]  cor_ang;
  logic [31:0]  res_x_q, res_y_q, res_h_q;
  logic [17:0]  res_z_q, res_w_q;
  logic         res_meth_q;

  always_comb begin
    trig = (cmd_i.mul_sel == odo_pkg::MUL_DIST_SIN) ? 64'($signed(sn_q)) : 64'($signed(cs_q));
    case (cmd_i.mul_sel)
      odo_pkg::MUL_RATE_DT: begin
        mul_a   = {64'd0, odo_pkg::mag64(dt_q)};
        mul_b   = odo_pkg::mag64({{32{rate_q[31]}}, rate_q});
        mul_neg = dt_q[63] ^ rate_q[31];
      end
      odo_pkg::MUL_TURN: begin
        mul_a   = p_q;
        mul_b   = odo_pkg::INV_TWO_PI_Q32;
        mul_neg = 1'b0;
      end
      odo_pkg::MUL_SPEED_DT: begin
        mul_a   = {64'd0, odo_pkg::mag64(dt_q)};
        mul_b   = odo_pkg::mag64({{32{speed_q[31]}}, speed_q});
        mul_neg = dt_q[63] ^ speed_q[31];
      end
      odo_pkg::MUL_DIST_COS, odo_pkg::MUL_DIST_SIN: begin
        mul_a   = {64'd0, odo_pkg::mag64(dist_q)};
        mul_b   = odo_pkg::mag64(trig);
        mul_neg = dist_q[63] ^ trig[63];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
    cor_ang = cmd_i.cor_sel ? {1'b0, head_q[31:1]} : (meth_q ? head_q + half_q : head_q);
  end

  odo_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .neg_i  (mul_neg),
    .prod_o (prod),
    .done_o (mul_done)
  );

  odo_cordic #(.ITER(SINCOS_ITERATIONS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.cor_start),
    .ang_i  (cor_ang),
    .sin_o  (sn),
    .cos_o  (cs),
    .done_o (cor_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q    <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
      ref_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) method_q <= cfg_wr_data_i;
      if (in_fire_i && (action_i == odo_pkg::ACT_SET_POSE || action_i == odo_pkg::ACT_START)) begin
        pos_x_q <= new_x_i;
        pos_y_q <= new_y_i;
        head_q  <= new_heading_i;
        if (action_i == odo_pkg::ACT_START) ref_q <= timestamp_i;
      end
      if (cmd_i.upd_x) pos_x_q <= odo_pkg::move_axis(pos_x_q, odo_pkg::shift_sat(prod, 6'd30));
      if (cmd_i.upd_y) begin
        pos_y_q <= odo_pkg::move_axis(pos_y_q, odo_pkg::shift_sat(prod, 6'd30));
        head_q  <= head_q + dh_q;
        ref_q   <= ts_q;
      end
      // hold a new result, drop the beat once taken
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      speed_q <= linear_velocity_i;
      rate_q  <= angular_velocity_i;
      ts_q    <= timestamp_i;
      meth_q  <= method_q;
    end
    if (cmd_i.load_dt)    dt_q   <= ts_q - ref_q;
    if (cmd_i.store_p)    p_q    <= prod;
    if (cmd_i.store_q) begin
      dh_q   <= prod[POS_FRAC_BITS+32 +: 32];
      half_q <= prod[POS_FRAC_BITS+33 +: 32];
    end
    if (cmd_i.store_dist) dist_q <= odo_pkg::shift_sat(prod, 6'd32);
    if (cmd_i.store_trig) begin
      sn_q <= sn;
      cs_q <= cs;
    end
    if (cmd_i.out_load) begin
      res_x_q    <= pos_x_q;
      res_y_q    <= pos_y_q;
      res_h_q    <= head_q;
      res_z_q    <= odo_pkg::quat_q16(sn);
      res_w_q    <= odo_pkg::quat_q16(cs);
      res_meth_q <= meth_q;
    end
  end

  assign pose_x_o       = res_x_q;
  assign pose_y_o       = res_y_q;
  assign pose_heading_o = res_h_q;
  assign orient_z_o     = res_z_q;
  assign orient_w_o     = res_w_q;
  assign method_used_o  = res_meth_q;
  assign out_valid_o    = out_valid_q;
  assign sts_o.mul_done = mul_done;
  assign sts_o.cor_done = cor_done;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule

FILE: hdl/odo_ctrl.sv
// Controller state machine: sequences the multiplies, CORDIC runs and pose updates.
// Depends on odo_pkg for the command and status structs.
module odo_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       action_i,
  output logic             in_ready_o,
  input  odo_pkg::status_t sts_i,
  output odo_pkg::cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_DT = 5'd1,  S_M1 = 5'd2,  S_W1 = 5'd3,
                         S_M2   = 5'd4,  S_W2 = 5'd5,  S_M3 = 5'd6,  S_W3 = 5'd7,
                         S_C1   = 5'd8,  S_V1 = 5'd9,  S_M4 = 5'd10, S_W4 = 5'd11,
                         S_M5   = 5'd12, S_W5 = 5'd13, S_C2 = 5'd14, S_V2 = 5'd15,
                         S_OUT  = 5'd16;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && action_i == odo_pkg::ACT_UPDATE) state_d = S_DT;
      end
      S_DT: begin
        cmd_o.load_dt = 1'b1;
        state_d = S_M1;
      end
      S_M1: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = odo_pkg::MUL_RATE_DT;
        state_d = S_W1;
      end
      S_W1: if (sts_i.mul_done) begin
        cmd_o.store_p = 1'b1;
        state_d = S_M2;
      end
      S_M2: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = odo_pkg::MUL_TURN;
        state_d = S_W2;
      end
      S_W2: if (sts_i.mul_done) begin
        cmd_o.store_q = 1'b1;
        state_d = S_M3;
      end
      S_M3: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = odo_pkg::MUL_SPEED_DT;
        state_d = S_W3;
      end
      S_W3: if (sts_i.mul_done) begin
        cmd_o.store_dist = 1'b1;
        state_d = S_C1;
      end
      S_C1: begin
        cmd_o.cor_start = 1'b1;
        state_d = S_V1;
      end
      S_V1: if (sts_i.cor_done) begin
        cmd_o.store_trig = 1'b1;
        state_d = S_M4;
      end
      S_M4: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = odo_pkg::MUL_DIST_COS;
        state_d = S_W4;
      end
      S_W4: begin
        cmd_o.mul_sel = odo_pkg::MUL_DIST_COS;
        if (sts_i.mul_done) begin
          cmd_o.upd_x = 1'b1;
          state_d = S_M5;
        end
      end
      S_M5: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = odo_pkg::MUL_DIST_SIN;
        state_d = S_W5;
      end
      S_W5: if (sts_i.mul_done) begin
        cmd_o.upd_y = 1'b1;
        state_d = S_C2;
      end
      S_C2: begin
        cmd_o.cor_start = 1'b1;
        cmd_o.cor_sel   = 1'b1;
        state_d = S_V2;
      end
      S_V2: if (sts_i.cor_done) state_d = S_OUT;
      S_OUT: if (!sts_i.out_busy) begin
        cmd_o.out_load = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

FILE: hdl/planar_odometry_integrator_unit.sv
// Top level of the planar odometry integrator: stream ports, controller and datapath.
// Depends on odo_pkg, odo_ctrl and odo_dpath.
//
// Integrates a planar pose from timestamped speed and turn-rate beats, Euler or midpoint
// Runge-Kutta as the method register selects, and emits pose plus yaw quaternion. Set-pose
// and start beats emit nothing. A velocity update runs five products through one 32x32
// multiplier at one partial product per cycle, and two sine/cosine evaluations of an
// iterative CORDIC; the next beat is taken only once its result is loaded for output. A new
// beat is taken while the last result still waits; a result that the sink has not yet taken
// holds the next one back until the sink takes it.
module planar_odometry_integrator_unit #(
  parameter int SINCOS_ITERATIONS = 16,
  parameter int POS_FRAC_BITS     = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_wr_en_i,
  input  logic         cfg_wr_data_i,    // method: 0 Euler, 1 midpoint
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // linear_velocity, angular_velocity, timestamp, new_x, new_y, new_heading
  input  logic [223:0] s_axis_tdata_i,
  input  logic [1:0]   s_axis_tuser_i,   // action
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // pose_x, pose_y, pose_heading, orient_z, orient_w, zero pad
  output logic [135:0] m_axis_tdata_o,
  output logic         m_axis_tuser_o    // method_used
);

  odo_pkg::cmd_t    cmd;
  odo_pkg::status_t sts;
  logic             in_fire;
  logic [31:0]      px, py, ph;
  logic [17:0]      oz, ow;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  odo_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .action_i  (s_axis_tuser_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  odo_dpath #(
    .SINCOS_ITERATIONS(SINCOS_ITERATIONS),
    .POS_FRAC_BITS    (POS_FRAC_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_fire_i         (in_fire),
    .action_i          (s_axis_tuser_i),
    .linear_velocity_i (s_axis_tdata_i[31:0]),
    .angular_velocity_i(s_axis_tdata_i[63:32]),
    .timestamp_i       (s_axis_tdata_i[127:64]),
    .new_x_i           (s_axis_tdata_i[159:128]),
    .new_y_i           (s_axis_tdata_i[191:160]),
    .new_heading_i     (s_axis_tdata_i[223:192]),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .out_ready_i       (m_axis_tready_i),
    .out_valid_o       (m_axis_tvalid_o),
    .pose_x_o          (px),
    .pose_y_o          (py),
    .pose_heading_o    (ph),
    .orient_z_o        (oz),
    .orient_w_o        (ow),
    .method_used_o     (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {4'd0, ow, oz, ph, py, px};

endmodule

FILE: bench/tb.sv
// Self-checking bench for planar_odometry_integrator_unit: a directed table, then random
// phases under both integration methods, checked against an in-bench pose predictor.
// Depends on odo_pkg for the action codes and on the RTL top level.
module tb;

  localparam logic [1:0]  ACT_RESERVED = 2'd3;
  localparam logic        METHOD_EULER = 1'b0;
  localparam logic        METHOD_MID   = 1'b1;
  localparam int          RAND_PER_PHASE = 150;
  localparam logic [63:0] GAIN_Q30 = 64'd652032875;
  localparam logic [127:0] TURN_PER_RAD_Q32 = 128'd683565276;

  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] lin;
    logic [31:0] ang;
    logic [63:0] ts;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nh;
    logic        typed;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] eh;
  } odo_beat_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] h;
    logic [17:0] qz;
    logic [17:0] qw;
    logic        meth;
  } pose_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_wr_data = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [223:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic         m_tuser;

  // predictor state
  logic signed [31:0] est_x, est_y;
  logic [31:0]        est_heading;
  logic [63:0]        est_ref_time;
  logic               est_method;

  pose_t       expected_poses[$];
  int          fail_count = 0;
  int          poses_checked = 0;
  int          beats_sent = 0;
  logic        no_gaps = 1'b0;
  odo_beat_t   dir_rows[16];

  planar_odometry_integrator_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] atan_step(input int i);
    logic [31:0] t [16];
    t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
          32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
          32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861};
    return t[i];
  endfunction

  function automatic logic signed [127:0] wide_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [127:0] ea, eb;
    ea = a;
    eb = b;
    return ea * eb;
  endfunction

  function automatic logic signed [63:0] shr_sat64(input logic signed [127:0] v, input int s);
    logic signed [127:0] sh;
    sh = v >>> s;
    if ((&sh[127:63]) || !(|sh[127:63])) return sh[63:0];
    return v[127] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
  endfunction

  // rotation CORDIC on a binary angle, results in Q2.30
  task automatic sin_cos(input logic [31:0] ang, output logic signed [63:0] sn,
                         output logic signed [63:0] cs);
    logic [31:0] a;
    logic signed [63:0] x, y, z, dx, dy;
    logic        flip;
    a = ang + 32'h4000_0000;
    flip = a[31];
    a = flip ? ang - 32'h8000_0000 : ang;
    z = $signed(a);
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - $signed({32'd0, atan_step(i)});
      end else begin
        x = x + dx; y = y - dy; z = z + $signed({32'd0, atan_step(i)});
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  function automatic logic signed [31:0] shift_pos(input logic signed [31:0] pos,
                                                   input logic signed [63:0] travel,
                                                   input logic signed [63:0] trig);
    logic signed [63:0] d, r;
    d = shr_sat64(wide_mul(travel, trig), 30);
    if (d > 64'sh2_0000_0000) d = 64'sh2_0000_0000;
    if (d < -64'sh2_0000_0000) d = -64'sh2_0000_0000;
    r = 64'(pos) + d;
    if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
    if (r < -64'sh8000_0000) r = -64'sh8000_0000;
    return r[31:0];
  endfunction

  function automatic logic [17:0] to_q16(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd8192) >>> 14;
    if (r > 64'sd65536) r = 64'sd65536;
    if (r < -64'sd65536) r = -64'sd65536;
    return r[17:0];
  endfunction

  // advance the predicted pose by one accepted beat; returns 1 when a pose is due
  task automatic integrate_beat(input odo_beat_t b, output logic emits, output pose_t p);
    logic signed [63:0]  dt, travel, sn, cs;
    logic [127:0]        turn;
    logic [31:0]         dh, half;
    emits = 1'b0;
    p = '0;
    if (b.act == odo_pkg::ACT_SET_POSE || b.act == odo_pkg::ACT_START) begin
      est_x = b.nx;
      est_y = b.ny;
      est_heading = b.nh;
      if (b.act == odo_pkg::ACT_START) est_ref_time = b.ts;
    end else if (b.act == odo_pkg::ACT_UPDATE) begin
      dt = b.ts - est_ref_time;
      turn = wide_mul($signed(b.ang), dt) * TURN_PER_RAD_Q32;
      dh = turn[79:48];
      half = turn[80:49];
      sin_cos(est_method ? est_heading + half : est_heading, sn, cs);
      travel = shr_sat64(wide_mul($signed(b.lin), dt), 32);
      est_x = shift_pos(est_x, travel, cs);
      est_y = shift_pos(est_y, travel, sn);
      est_heading = est_heading + dh;
      est_ref_time = b.ts;
      sin_cos({1'b0, est_heading[31:1]}, sn, cs);
      p = '{est_x, est_y, est_heading, to_q16(sn), to_q16(cs), est_method};
      emits = 1'b1;
    end
  endtask

  task automatic send_beat(input odo_beat_t b);
    int    gap;
    logic  emits;
    pose_t p;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= b.act;
    s_tdata  <= {b.nh, b.ny, b.nx, b.ts, b.ang, b.lin};
    do @(posedge clk_i); while (!s_tready);
    beats_sent++;
    integrate_beat(b, emits, p);
    if (emits) begin
      if (b.typed) begin
        p.x = b.ex; p.y = b.ey; p.h = b.eh;
      end
      expected_poses.push_back(p);
    end
  endtask

  // drain, let a trailing load beat settle, then write the method
  task automatic set_method(input logic m);
    s_tvalid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk_i);
    cfg_wr_en   <= 1'b0;
    est_method = m;
  endtask

  function automatic logic [31:0] rand_speed();
    logic [31:0] v;
    v = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h6_0000) - 32'h3_0000;
    return v;
  endfunction

  function automatic odo_beat_t rand_beat();
    odo_beat_t b;
    int        r;
    logic [63:0] step;
    b = '0;
    r = $urandom_range(0, 99);
    b.lin = rand_speed();
    b.ang = rand_speed();
    b.nx  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h200_0000) - 32'h100_0000;
    b.ny  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h200_0000) - 32'h100_0000;
    b.nh  = $urandom;
    step  = {30'd0, 2'($urandom_range(0, 3)), 32'($urandom)};
    case ($urandom_range(0, 19))
      0:       b.ts = {$urandom, $urandom};
      1:       b.ts = est_ref_time - step;
      default: b.ts = est_ref_time + step;
    endcase
    if (r < 6)       b.act = odo_pkg::ACT_START;
    else if (r < 11) b.act = odo_pkg::ACT_SET_POSE;
    else if (r < 14) b.act = ACT_RESERVED;
    else             b.act = odo_pkg::ACT_UPDATE;
    return b;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
      fail_count++;
    end
  endfunction

  // result side: random stalls, compare each pose beat with the oldest prediction
  initial begin
    int    stall;
    pose_t e;
    @(posedge rst_ni);
    forever begin
      stall = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      if (expected_poses.size() == 0) begin
        $display("%0t unexpected pose beat %h", $time, m_tdata);
        fail_count++;
      end else begin
        e = expected_poses.pop_front();
        poses_checked++;
        check_field("pose_x", e.x, m_tdata[31:0]);
        check_field("pose_y", e.y, m_tdata[63:32]);
        check_field("pose_heading", e.h, m_tdata[95:64]);
        check_field("orient_z", 32'(e.qz), 32'(m_tdata[113:96]));
        check_field("orient_w", 32'(e.qw), 32'(m_tdata[131:114]));
        check_field("method_used", 32'(e.meth), 32'(m_tuser));
      end
    end
  end

  initial begin
    dir_rows[0]  = '{odo_pkg::ACT_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'd0, 32'd0, 32'd0,
                     32'd0, 1'b1, 32'd0, 32'd0, 32'd0};
    dir_rows[1]  = '{ACT_RESERVED, '1, '1, '1, '1, '1, '1, 1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[2]  = '{odo_pkg::ACT_START, 32'd0, 32'd0, 64'h1_0000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[3]  = '{odo_pkg::ACT_UPDATE, 32'h8000_0000, 32'h8000_0000, 64'h1_0000_0000,
                     32'd0, 32'd0, 32'd0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0};
    dir_rows[4]  = '{odo_pkg::ACT_UPDATE, 32'h7FFF_FFFF, 32'd0, 64'h2_0000_0000, 32'd0,
                     32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[5]  = '{odo_pkg::ACT_SET_POSE, 32'd0, 32'd0, 64'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
                     1'b0, 32'd0, 32'd0, 32'd0};
    // timestamp behind the reference: negative dt
    dir_rows[6]  = '{odo_pkg::ACT_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 64'd0, 32'd0, 32'd0,
                     32'd0, 1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[7]  = '{odo_pkg::ACT_UPDATE, 32'h0001_0000, 32'h8000_0000, '1, 32'd0, 32'd0,
                     32'd0, 1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[8]  = '{odo_pkg::ACT_START, 32'h5555_5555, 32'hAAAA_AAAA, '1, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[9]  = '{odo_pkg::ACT_UPDATE, 32'h0001_0000, 32'h0001_0000, 64'd0, 32'd0, 32'd0,
                     32'd0, 1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[10] = '{odo_pkg::ACT_UPDATE, 32'h0001_0000, 32'h0001_921F, 64'h1_0000_0000,
                     32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[11] = '{odo_pkg::ACT_SET_POSE, 32'd0, 32'd0, 64'd0, 32'd0, 32'd0, 32'h4000_0000,
                     1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[12] = '{odo_pkg::ACT_UPDATE, 32'hFFFF_0000, 32'd0, 64'h2_8000_0000, 32'd0,
                     32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[13] = '{odo_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h2_8000_0001,
                     32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[14] = '{odo_pkg::ACT_SET_POSE, 32'd0, 32'd0, 64'd0, 32'h0001_2345, 32'hFFFF_FFFF,
                     32'hC000_0000, 1'b0, 32'd0, 32'd0, 32'd0};
    dir_rows[15] = '{odo_pkg::ACT_UPDATE, 32'h1234_5678, 32'h8765_4321, 64'h2_8000_0001,
                     32'd0, 32'd0, 32'd0, 1'b1, 32'h0001_2345, 32'hFFFF_FFFF, 32'hC000_0000};

    est_x = 0; est_y = 0; est_heading = 0; est_ref_time = 0; est_method = METHOD_EULER;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_method(METHOD_EULER);
    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    for (int ph = 0; ph < 3; ph++) begin
      set_method(ph == 1 ? METHOD_EULER : METHOD_MID);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // a stretch without idling on either side in every phase
        no_gaps = (n >= 60 && n < 100);
        send_beat(rand_beat());
      end
      no_gaps = 1'b0;
    end

    s_tvalid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d beats (loads, starts, reserved, updates) over Euler and midpoint",
             beats_sent);
    $display("phases; %0d pose beats compared field by field.", poses_checked);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
